// ===== hw/rtl/htrd_pkg.sv =====
`timescale 1ns / 1ps
package htrd_pkg;

   localparam int SYMBOL_WIDTH = 8;
   localparam int STATUS_WIDTH = 3;
   localparam int HDR_WIDTH    = 12;
   localparam int CMD_WIDTH    = 2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_START   = 2'd0,
      CMD_HEADER  = 2'd1,
      CMD_PAYLOAD = 2'd2,
      CMD_NONE    = 2'd3
   } command_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_SYMBOL    = 3'd0,
      ST_HDR_DONE  = 3'd1,
      ST_TRUNCATED = 3'd2,
      ST_MISSING   = 3'd3,
      ST_BAD_ROOT  = 3'd4,
      ST_OVERFLOW  = 3'd5,
      ST_NO_TREE   = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HDR_BIT,
      S_POP_RIGHT,
      S_POP_LEFT,
      S_JOIN,
      S_FIN_READ,
      S_FIN_CHECK,
      S_PAY_READ,
      S_PAY_STEP,
      S_PAY_LEAF,
      S_EMIT
   } state_type;

endpackage

// ===== hw/rtl/htrd_req_if.sv =====
`timescale 1ns / 1ps
interface htrd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;
   modport source (output valid, command, data_byte, input ready);
   modport sink (input valid, command, data_byte, output ready);
endinterface

// ===== hw/rtl/htrd_rsp_if.sv =====
`timescale 1ns / 1ps
interface htrd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic [2:0] status;
   logic       last;
   modport source (output valid, symbol, status, last, input ready);
   modport sink (input valid, symbol, status, last, output ready);
endinterface

// ===== hw/rtl/huffman_tree_rebuild_decoder.sv =====
`timescale 1ns / 1ps
// A header beat is handled bit by bit in S_HDR_BIT; each join adds S_POP_RIGHT, S_POP_LEFT and
// S_JOIN, and completion adds S_FIN_READ and S_FIN_CHECK. A payload bit takes a node store
// read, register and step, plus an S_EMIT step per emitted symbol; the node store read per
// bit sets the rate. Results leave through one output register; a beat is taken only when idle.
// Reset (synchronous, active high) clears control state and header_bits; the
// node store and index stack are not cleared.
module huffman_tree_rebuild_decoder #(
   parameter int NODE_DEPTH  = 512,
   parameter int STACK_DEPTH = 256
) (
   input  logic clock,
   input  logic reset,
   htrd_req_if.sink   req,
   htrd_rsp_if.source rsp,
   input  logic        csr_we,
   input  logic [11:0] csr_wdata
);
   import htrd_pkg::*;

   localparam int NW = $clog2(NODE_DEPTH);
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int NODE_BITS = 1 + SYMBOL_WIDTH + 2 * NW;

   logic [NODE_BITS-1:0] node_mem [NODE_DEPTH];
   logic [NW-1:0]        stack_mem [STACK_DEPTH];

   state_type state_ff, state_in;
   logic [HDR_WIDTH-1:0] hdr_bits_ff, hdr_pos_ff, hdr_pos_in;
   logic [SW:0]          top_ff, top_in;
   logic [NW:0]          free_ff, free_in;
   logic [3:0]           leaf_left_ff, leaf_left_in;
   logic [7:0]           leaf_val_ff, leaf_val_in;
   logic [NW-1:0]        root_ff, root_in, cur_ff, cur_in;
   logic                 ready_ff, ready_in, err_ff, err_in;
   logic [7:0]           shift_ff, shift_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [NW-1:0]        rgt_ff, rgt_in, lft_ff, lft_in;
   logic [NODE_BITS-1:0] nrd_ff;
   logic [NW-1:0]        srd_ff;
   logic                 rv_ff, rv_in, rlast_ff, rlast_in;
   logic [2:0]           rst_ff, rst_in;
   logic [7:0]           rsym_ff, rsym_in;
   logic                 pend_ff, pend_in, elast_ff, elast_in;
   logic [7:0]           psym_ff, psym_in;

   logic                 n_re, n_we, s_re, s_we;
   logic [NW-1:0]        n_ra, n_wa;
   logic [NODE_BITS-1:0] n_wd;
   logic [SW-1:0]        s_ra, s_wa;
   logic [NW-1:0]        s_wd;

   logic                 bit_v, nd_leaf;
   logic [7:0]           nd_val;
   logic [NW-1:0]        nd_l, nd_r, nx;
   logic [HDR_WIDTH:0]   pos_p1, need;

   state_type            prev_ff;
   logic                 fin_pend;
   logic                 rv_x, rlast_x, ready_x, err_x;
   logic [2:0]           rst_x;
   logic [NW-1:0]        root_x, cur_x;

   assign bit_v   = shift_ff[7];
   assign nd_leaf = nrd_ff[NODE_BITS-1];
   assign nd_val  = nrd_ff[NODE_BITS-2 -: 8];
   assign nd_l    = nrd_ff[2*NW-1 -: NW];
   assign nd_r    = nrd_ff[NW-1:0];
   assign nx      = bit_v ? nd_r : nd_l;
   assign pos_p1  = {1'b0, hdr_pos_ff} + 1'b1;
   assign need    = pos_p1 + 13'd8;

   // Finishing check uses the node read issued in the cycle before.
   assign fin_pend = (prev_ff == S_FIN_CHECK);

   assign req.ready  = (state_ff == S_IDLE) && !rv_ff && !fin_pend;
   assign rsp.valid  = rv_ff;
   assign rsp.symbol = rsym_ff;
   assign rsp.status = rst_ff;
   assign rsp.last   = rlast_ff;

   always_ff @(posedge clock) begin
      if (n_we) node_mem[n_wa] <= n_wd;
      if (n_re) nrd_ff <= node_mem[n_ra];
      if (s_we) stack_mem[s_wa] <= s_wd;
      if (s_re) srd_ff <= stack_mem[s_ra];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               case (command_type'(req.command))
                  CMD_START:   state_in = (hdr_bits_ff == '0) ? S_FIN_READ : S_IDLE;
                  CMD_HEADER:  state_in = (ready_ff || err_ff || hdr_pos_ff >= hdr_bits_ff)
                                          ? S_IDLE : S_HDR_BIT;
                  CMD_PAYLOAD: state_in = ready_ff ? S_PAY_READ : S_IDLE;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_HDR_BIT: begin
            if (leaf_left_ff != 4'd0) begin
               if (leaf_left_ff == 4'd1 &&
                   (free_ff >= (NW+1)'(NODE_DEPTH) || top_ff >= (SW+1)'(STACK_DEPTH)))
                  state_in = S_IDLE;
               else if (pos_p1[HDR_WIDTH-1:0] >= hdr_bits_ff) state_in = S_FIN_READ;
               else if (cnt_ff == 4'd1) state_in = S_IDLE;
            end else if (bit_v) begin
               if (need > {1'b0, hdr_bits_ff}) state_in = S_IDLE;
               else if (pos_p1[HDR_WIDTH-1:0] >= hdr_bits_ff) state_in = S_FIN_READ;
               else if (cnt_ff == 4'd1) state_in = S_IDLE;
            end else begin
               if (top_ff < (SW+1)'(2) || free_ff >= (NW+1)'(NODE_DEPTH)) state_in = S_IDLE;
               else state_in = S_POP_RIGHT;
            end
         end
         S_POP_RIGHT: state_in = S_POP_LEFT;
         S_POP_LEFT:  state_in = S_JOIN;
         S_JOIN: begin
            if (hdr_pos_ff >= hdr_bits_ff) state_in = S_FIN_READ;
            else if (cnt_ff == 4'd0) state_in = S_IDLE;
            else state_in = S_HDR_BIT;
         end
         S_FIN_READ:  state_in = (top_ff != (SW+1)'(1)) ? S_IDLE : S_FIN_CHECK;
         S_FIN_CHECK: state_in = S_IDLE;
         S_PAY_READ:  state_in = S_PAY_STEP;
         S_PAY_STEP:  state_in = S_PAY_LEAF;
         S_PAY_LEAF: begin
            if (nd_leaf) state_in = (pend_ff || cnt_ff == 4'd1) ? S_EMIT : S_PAY_READ;
            else if (cnt_ff == 4'd1) state_in = pend_ff ? S_EMIT : S_IDLE;
            else state_in = S_PAY_READ;
         end
         S_EMIT: begin
            if (!rv_ff || rsp.ready) begin
               if (elast_ff) state_in = S_IDLE;
               else if (cnt_ff == 4'd0) state_in = S_EMIT;
               else state_in = S_PAY_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      hdr_pos_in = hdr_pos_ff; top_in = top_ff; free_in = free_ff;
      leaf_left_in = leaf_left_ff; leaf_val_in = leaf_val_ff;
      root_in = root_ff; cur_in = cur_ff; ready_in = ready_ff; err_in = err_ff;
      shift_in = shift_ff; cnt_in = cnt_ff; rgt_in = rgt_ff; lft_in = lft_ff;
      rv_in = rv_ff && !rsp.ready; rlast_in = rlast_ff; rst_in = rst_ff; rsym_in = rsym_ff;
      pend_in = pend_ff; elast_in = elast_ff; psym_in = psym_ff;
      n_re = 1'b0; n_we = 1'b0; s_re = 1'b0; s_we = 1'b0;
      n_ra = cur_ff; n_wa = free_ff[NW-1:0]; n_wd = '0;
      s_ra = '0; s_wa = top_ff[SW-1:0]; s_wd = free_ff[NW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               shift_in = req.data_byte;
               cnt_in   = 4'd8;
               if (command_type'(req.command) == CMD_START) begin
                  hdr_pos_in = '0; top_in = '0; free_in = '0; leaf_left_in = '0;
                  leaf_val_in = '0; root_in = '0; cur_in = '0;
                  ready_in = 1'b0; err_in = 1'b0;
               end else if (command_type'(req.command) == CMD_PAYLOAD && !ready_ff) begin
                  rv_in = 1'b1; rsym_in = '0; rst_in = ST_NO_TREE; rlast_in = 1'b1;
               end
            end
         end
         S_HDR_BIT: begin
            hdr_pos_in = pos_p1[HDR_WIDTH-1:0];
            shift_in = {shift_ff[6:0], 1'b0};
            cnt_in = cnt_ff - 4'd1;
            rsym_in = '0; rlast_in = 1'b1;
            if (leaf_left_ff != 4'd0) begin
               leaf_val_in = {leaf_val_ff[6:0], bit_v};
               leaf_left_in = leaf_left_ff - 4'd1;
               if (leaf_left_ff == 4'd1) begin
                  if (free_ff >= (NW+1)'(NODE_DEPTH) || top_ff >= (SW+1)'(STACK_DEPTH)) begin
                     err_in = 1'b1; rv_in = 1'b1; rst_in = ST_OVERFLOW;
                  end else begin
                     n_we = 1'b1;
                     n_wd = {1'b1, leaf_val_ff[6:0], bit_v, {(2*NW){1'b0}}};
                     s_we = 1'b1;
                     top_in = top_ff + 1'b1;
                     free_in = free_ff + 1'b1;
                  end
               end
            end else if (bit_v) begin
               if (need > {1'b0, hdr_bits_ff}) begin
                  err_in = 1'b1; rv_in = 1'b1; rst_in = ST_TRUNCATED;
               end else begin
                  leaf_left_in = 4'd8; leaf_val_in = '0;
               end
            end else begin
               if (top_ff < (SW+1)'(2)) begin
                  err_in = 1'b1; rv_in = 1'b1; rst_in = ST_MISSING;
               end else if (free_ff >= (NW+1)'(NODE_DEPTH)) begin
                  err_in = 1'b1; rv_in = 1'b1; rst_in = ST_OVERFLOW;
               end else begin
                  s_re = 1'b1; s_ra = SW'(top_ff - 1'b1);
               end
            end
         end
         S_POP_RIGHT: begin
            rgt_in = srd_ff;
            s_re = 1'b1; s_ra = SW'(top_ff - 2'd2);
         end
         S_POP_LEFT: ;
         S_JOIN: begin
            n_we = 1'b1;
            n_wd = {1'b0, 8'd0, srd_ff, rgt_ff};
            s_we = 1'b1; s_wa = SW'(top_ff - 2'd2);
            top_in = top_ff - 1'b1;
            free_in = free_ff + 1'b1;
         end
         S_FIN_READ: begin
            rsym_in = '0; rlast_in = 1'b1;
            if (top_ff != (SW+1)'(1)) begin
               err_in = 1'b1; rv_in = 1'b1; rst_in = ST_BAD_ROOT;
            end else begin
               s_re = 1'b1; s_ra = '0;
            end
         end
         S_FIN_CHECK: begin
            n_re = 1'b1; n_ra = srd_ff; lft_in = srd_ff;
         end
         S_PAY_READ: begin
            n_re = 1'b1; n_ra = cur_ff;
         end
         S_PAY_STEP: begin
            n_re = 1'b1; n_ra = nx; cur_in = nx;
         end
         S_PAY_LEAF: begin
            shift_in = {shift_ff[6:0], 1'b0};
            cnt_in = cnt_ff - 4'd1;
            elast_in = 1'b1;
            if (nd_leaf) begin
               cur_in = root_ff;
               if (pend_ff) begin
                  elast_in = 1'b0;
               end else begin
                  pend_in = 1'b1; psym_in = nd_val;
               end
            end
         end
         S_EMIT: begin
            if (!rv_ff || rsp.ready) begin
               rv_in = 1'b1; rst_in = ST_SYMBOL; rsym_in = psym_ff; rlast_in = elast_ff;
               if (elast_ff) begin
                  pend_in = 1'b0;
               end else begin
                  psym_in = nd_val;
                  elast_in = (cnt_ff == 4'd0);
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rv_x = rv_in; rst_x = rst_in; rlast_x = rlast_in;
      ready_x = ready_in; err_x = err_in; root_x = root_in; cur_x = cur_in;
      if (fin_pend) begin
         rv_x = 1'b1; rlast_x = 1'b1;
         if (nd_leaf) begin
            err_x = 1'b1; rst_x = ST_NO_TREE;
         end else begin
            ready_x = 1'b1; rst_x = ST_HDR_DONE; root_x = lft_ff; cur_x = lft_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; prev_ff <= S_IDLE;
         hdr_bits_ff <= '0; hdr_pos_ff <= '0; top_ff <= '0; free_ff <= '0;
         leaf_left_ff <= '0; leaf_val_ff <= '0; root_ff <= '0; cur_ff <= '0;
         ready_ff <= 1'b0; err_ff <= 1'b0; rv_ff <= 1'b0; cnt_ff <= '0; pend_ff <= 1'b0;
      end else begin
         state_ff <= fin_pend ? S_IDLE : state_in;
         prev_ff <= state_ff;
         if (csr_we) hdr_bits_ff <= csr_wdata;
         hdr_pos_ff <= hdr_pos_in; top_ff <= top_in; free_ff <= free_in;
         leaf_left_ff <= leaf_left_in; leaf_val_ff <= leaf_val_in;
         root_ff <= root_x; cur_ff <= cur_x; ready_ff <= ready_x; err_ff <= err_x;
         rv_ff <= rv_x; cnt_ff <= cnt_in; pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in; rgt_ff <= rgt_in; lft_ff <= lft_in;
      rst_ff <= rst_x; rsym_ff <= rsym_in; rlast_ff <= rlast_x;
      psym_ff <= psym_in; elast_ff <= elast_in;
   end

endmodule

// ===== dv/huffman_tree_rebuild_decoder_tb.sv =====
`timescale 1ns / 1ps
module huffman_tree_rebuild_decoder_tb;
   import htrd_pkg::*;

   localparam int NODES = 512;
   localparam int STACK = 256;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [7:0] symbol;
      status_type status;
      logic       last;
   } decode_result_type;

   // Accepted beats are predicted here; results are checked against the oldest expectation
   class decode_scoreboard_type;
      logic        node_leaf [NODES];
      logic [7:0]  node_value [NODES];
      logic [8:0]  node_left [NODES];
      logic [8:0]  node_right [NODES];
      logic [8:0]  index_stack [STACK];
      int unsigned stack_top, next_free, hdr_pos, leaf_left;
      logic [7:0]  leaf_shift;
      logic [8:0]  root_node, cur_node;
      bit          tree_ready, error_seen;
      logic [11:0] header_bits;
      decode_result_type pending[$];
      int          errors;

      function new();
         header_bits = 0;
         errors = 0;
         clear_tree();
      endfunction

      function void clear_tree();
         stack_top = 0;
         next_free = 0;
         hdr_pos = 0;
         leaf_left = 0;
         leaf_shift = 0;
         root_node = 0;
         cur_node = 0;
         tree_ready = 0;
         error_seen = 0;
      endfunction

      function void push_status(status_type s);
         decode_result_type r;
         r.symbol = 0;
         r.status = s;
         r.last = 1;
         pending.push_back(r);
      endfunction

      function status_type finish_header();
         if (stack_top != 1) begin
            error_seen = 1;
            return ST_BAD_ROOT;
         end
         if (node_leaf[index_stack[0]]) begin
            error_seen = 1;
            return ST_NO_TREE;
         end
         root_node = index_stack[0];
         cur_node = index_stack[0];
         tree_ready = 1;
         return ST_HDR_DONE;
      endfunction

      // returns ST_SYMBOL when nothing is reported
      function status_type header_bit(bit b);
         hdr_pos = (hdr_pos + 1) & 12'hFFF;
         if (leaf_left > 0) begin
            leaf_shift = {leaf_shift[6:0], b};
            leaf_left--;
            if (leaf_left == 0) begin
               if (next_free >= NODES || stack_top >= STACK) begin
                  error_seen = 1;
                  return ST_OVERFLOW;
               end
               node_leaf[next_free] = 1;
               node_value[next_free] = leaf_shift;
               node_left[next_free] = 0;
               node_right[next_free] = 0;
               index_stack[stack_top] = 9'(next_free);
               stack_top++;
               next_free++;
            end
         end else if (b) begin
            if (hdr_pos + 8 > header_bits) begin
               error_seen = 1;
               return ST_TRUNCATED;
            end
            leaf_left = 8;
            leaf_shift = 0;
         end else begin
            if (stack_top < 2) begin
               error_seen = 1;
               return ST_MISSING;
            end
            if (next_free >= NODES) begin
               error_seen = 1;
               return ST_OVERFLOW;
            end
            node_leaf[next_free] = 0;
            node_value[next_free] = 0;
            node_right[next_free] = index_stack[stack_top-1];
            node_left[next_free] = index_stack[stack_top-2];
            stack_top -= 2;
            index_stack[stack_top] = 9'(next_free);
            stack_top++;
            next_free++;
         end
         if (hdr_pos >= header_bits) return finish_header();
         return ST_SYMBOL;
      endfunction

      function void note_beat(command_type cmd, logic [7:0] data);
         status_type st;
         logic [8:0] nx;
         int n;
         decode_result_type r;
         case (cmd)
            CMD_START: begin
               clear_tree();
               if (header_bits == 0) push_status(finish_header());
            end
            CMD_HEADER: begin
               if (!tree_ready && !error_seen) begin
                  for (int i = 7; i >= 0; i--) begin
                     if (hdr_pos >= header_bits) break;
                     st = header_bit(data[i]);
                     if (st != ST_SYMBOL) begin
                        push_status(st);
                        break;
                     end
                  end
               end
            end
            CMD_PAYLOAD: begin
               if (!tree_ready) push_status(ST_NO_TREE);
               else begin
                  n = 0;
                  for (int i = 7; i >= 0; i--) begin
                     nx = data[i] ? node_right[cur_node] : node_left[cur_node];
                     if (node_leaf[nx]) begin
                        r.symbol = node_value[nx];
                        r.status = ST_SYMBOL;
                        r.last = 0;
                        pending.push_back(r);
                        n++;
                        cur_node = root_node;
                     end else cur_node = nx;
                  end
                  if (n > 0) pending[$].last = 1;
               end
            end
            default: ;
         endcase
      endfunction

      task check_result(decode_result_type got);
         decode_result_type want;
         if (pending.size() == 0) begin
            report_mismatch("result with nothing expected", 0, got.status);
            return;
         end
         want = pending.pop_front();
         if (got.symbol !== want.symbol)
            report_mismatch("symbol", want.symbol, got.symbol);
         if (got.status !== want.status)
            report_mismatch("status", want.status, got.status);
         if (got.last !== want.last)
            report_mismatch("last", want.last, got.last);
      endtask

      task report_mismatch(string what, int want, int got);
         $display("MISMATCH %s: expected %0d got %0d at %0t", what, want, got, $realtime);
         errors++;
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [11:0] csr_wdata = 0;
   int idle_cycles = 0;
   int rsp_phase = 0;
   bit stall_mode = 0;

   htrd_req_if req();
   htrd_rsp_if rsp();
   decode_scoreboard_type board = new();

   huffman_tree_rebuild_decoder DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   initial begin
      req.valid = 0;
      req.command = CMD_NONE;
      req.data_byte = 0;
      rsp.ready = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready)
            board.check_result('{rsp.symbol, status_type'(rsp.status), rsp.last});
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("huffman_tree_rebuild_decoder verification failed");
            $finish;
         end
      end
   end

   // receiver stall pattern: runs of ready with a periodic drop, or random
   always @(negedge clock) begin
      rsp_phase <= rsp_phase + 1;
      if (rsp_phase % 97 == 0) stall_mode <= 1'($urandom_range(0, 1));
      rsp.ready <= stall_mode ? ($urandom_range(0, 3) != 0) : (rsp_phase % 5 != 4);
   end

   int burst_left = 0;

   task automatic send_beat(command_type cmd, logic [7:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req.valid <= 0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req.valid <= 1;
      req.command <= cmd;
      req.data_byte <= data;
      do @(posedge clock); while (!req.ready);
      board.note_beat(cmd, data);
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_header_bits(logic [11:0] v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      board.header_bits = v;
   endtask

   // serialise a bit string MSB first into header beats
   task automatic send_header(logic bits [$]);
      logic [7:0] b;
      while (bits.size() % 8 != 0) bits.push_back(1'($urandom_range(0, 1)));
      for (int i = 0; i < bits.size(); i += 8) begin
         for (int k = 0; k < 8; k++) b[7-k] = bits[i+k];
         send_beat(CMD_HEADER, b);
      end
   endtask

   // random well-formed post-order tree with the given leaf count
   function automatic void build_tree(int leaves, ref logic bits [$]);
      int depth = 0, made = 0;
      logic [7:0] v;
      bits.delete();
      while (made < leaves || depth > 1) begin
         if (made < leaves && (depth < 2 || $urandom_range(0, 1))) begin
            v = 8'($urandom);
            bits.push_back(1'b1);
            for (int k = 7; k >= 0; k--) bits.push_back(v[k]);
            made++;
            depth++;
         end else begin
            bits.push_back(1'b0);
            depth--;
         end
      end
   endfunction

   task automatic run_tree(int leaves, int payload, int noise);
      logic bits [$];
      build_tree(leaves, bits);
      write_header_bits(12'(bits.size()));
      send_beat(CMD_START, 0);
      send_header(bits);
      for (int i = 0; i < payload; i++) begin
         if ($urandom_range(0, 9) < noise)
            send_beat(command_type'($urandom_range(0, 3)), 8'($urandom));
         else send_beat(CMD_PAYLOAD, 8'($urandom));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: no tree, empty header, unknown command
      send_beat(CMD_PAYLOAD, 8'hFF);
      send_beat(CMD_START, 0);
      send_beat(CMD_NONE, 8'hA5);
      // lone leaf
      write_header_bits(9);
      send_beat(CMD_START, 0);
      send_beat(CMD_HEADER, 8'hFF);
      send_beat(CMD_HEADER, 8'h80);
      send_beat(CMD_HEADER, 8'h00);
      // missing children
      write_header_bits(8);
      send_beat(CMD_START, 0);
      send_beat(CMD_HEADER, 8'h00);
      // truncated leaf
      write_header_bits(5);
      send_beat(CMD_START, 0);
      send_beat(CMD_HEADER, 8'h80);
      // bad root count: two leaves, no join
      write_header_bits(18);
      send_beat(CMD_START, 0);
      send_header('{1,0,0,0,0,0,0,0,0, 1,1,1,1,1,1,1,1,1});
      // two leaves 0x00 and 0xFF, extremes of payload
      write_header_bits(19);
      send_beat(CMD_START, 0);
      send_header('{1,0,0,0,0,0,0,0,0, 1,1,1,1,1,1,1,1,1, 0});
      send_beat(CMD_HEADER, 8'hFF);
      send_beat(CMD_PAYLOAD, 8'h00);
      send_beat(CMD_PAYLOAD, 8'hFF);
      send_beat(CMD_PAYLOAD, 8'h5A);

      // random: mostly valid trees with payload, some noise
      for (int t = 0; t < 6; t++)
         run_tree($urandom_range(2, (t == 2) ? 16 : 8), $urandom_range(4, 10),
                  (t == 3) ? 4 : 0);
      write_header_bits(12'($urandom));
      send_beat(CMD_START, 0);
      for (int i = 0; i < 6; i++) send_beat(CMD_HEADER, 8'($urandom));
      write_header_bits(4095);
      send_beat(CMD_START, 0);

      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("huffman_tree_rebuild_decoder verification clean");
      else
         $display("huffman_tree_rebuild_decoder verification failed");
      $finish;
   end
endmodule

// ===== huffman_tree_rebuild_decoder.f =====
hw/rtl/htrd_pkg.sv
hw/rtl/htrd_req_if.sv
hw/rtl/htrd_rsp_if.sv
hw/rtl/huffman_tree_rebuild_decoder.sv
dv/huffman_tree_rebuild_decoder_tb.sv
